/* design/uer_pkg.sv */
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types, constants and the distance conversion of the echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  // default counter width and register reset values
  localparam int          COUNT_WIDTH_DEF = 16;
  localparam int          CFG_WIDTH       = 16;
  localparam logic [15:0] TRIGGER_RESET   = 16'd15;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd5000;
  localparam logic [7:0]  TIMEOUT_DIST    = 8'd127;
  localparam logic [7:0]  DIST_MAX        = 8'd255;

  // count*346/20000 reaches 256 from this count onwards
  localparam logic [31:0] DIST_SAT_COUNT  = 32'd14798;
  // 346 * ceil(2^38 / 20000), exact for counts below the saturation point
  localparam logic [46:0] DIST_MULT       = 47'd4755388016;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_TRIGGER_TICKS = 1'b0,
    CFG_TIMEOUT_TICKS = 1'b1
  } uer_cfg_idx_t;

  // measurement phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_FALL = 4'b1000
  } uer_phase_t;

  // one input item
  typedef struct packed {
    logic command;
    logic sensor_select;
    logic echo_left;
    logic echo_right;
  } uer_item_t;

  // one result item
  typedef struct packed {
    logic       trigger_left;
    logic       trigger_right;
    logic       busy_res;
    logic       done_res;
    logic       timed_out;
    logic [7:0] distance_cm;
  } uer_res_t;

  // echo high time in ticks to centimetres, saturated
  function automatic logic [7:0] uer_to_cm(input logic [31:0] cnt);
    logic [46:0] prod;
    prod = 47'(cnt[13:0]) * DIST_MULT;
    if (cnt >= DIST_SAT_COUNT) begin
      return DIST_MAX;
    end
    return prod[45:38];
  endfunction

endpackage

/* design/ultrasonic_echo_ranger.sv */
// Path: an accepted input is held in the input register, then the state update
// writes the result register, where the result waits until the downstream side takes it.
// Throughput: one item per cycle unless out_ready stalls; counter and phase update per item.
// Reset: synchronous, active low; idle phase, counter cleared, left sensor,
// trigger length 15 ticks and timeout 5000 ticks.
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger/echo controller for a left and a right ultrasonic range sensor.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_addr,
  input  logic [uer_pkg::CFG_WIDTH-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic                          in_sensor_select,
  input  logic                          in_echo_left,
  input  logic                          in_echo_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_trigger_left,
  output logic                          out_trigger_right,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic                          out_timed_out,
  output logic [7:0]                    out_distance_cm
);
  import uer_pkg::*;

  uer_item_t in_item, item;
  uer_res_t  res, out_res;
  logic      item_vld, advance;

  // pack the input fields
  always_comb begin
    in_item.command       = in_command;
    in_item.sensor_select = in_sensor_select;
    in_item.echo_left     = in_echo_left;
    in_item.echo_right    = in_echo_right;
  end

  uer_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  uer_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item_vld  (item_vld),
    .item      (item),
    .res       (res)
  );

  uer_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // unpack the result fields
  assign out_trigger_left  = out_res.trigger_left;
  assign out_trigger_right = out_res.trigger_right;
  assign out_busy_res      = out_res.busy_res;
  assign out_done_res      = out_res.done_res;
  assign out_timed_out     = out_res.timed_out;
  assign out_distance_cm   = out_res.distance_cm;

endmodule

/* design/uer_in_reg.sv */
// ----------------------------------------------------------------------------
// uer_in_reg
// Input register: holds one accepted item until the core stage takes it.
// ----------------------------------------------------------------------------
module uer_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  uer_pkg::uer_item_t in_item,
  input  logic              advance,
  output logic              item_vld,
  output uer_pkg::uer_item_t item
);
  import uer_pkg::*;

  logic      vld_r, vld_nxt;
  uer_item_t item_r;

  // free when empty or when the held item moves on this cycle
  assign in_ready = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture on each transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

/* design/uer_core.sv */
// ----------------------------------------------------------------------------
// uer_core
// Measurement state machine, tick counter and configuration registers.
// ----------------------------------------------------------------------------
module uer_core #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_addr,
  input  logic [uer_pkg::CFG_WIDTH-1:0]    cfg_wdata,
  input  logic                             advance,
  input  logic                             item_vld,
  input  uer_pkg::uer_item_t               item,
  output uer_pkg::uer_res_t                res
);
  import uer_pkg::*;

  // compare width covers both the counter and the 16-bit limits
  localparam int LW = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CEIL = {COUNT_WIDTH{1'b1}};

  logic [CFG_WIDTH-1:0]   trig_ticks_r, tmo_ticks_r;
  uer_phase_t             phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                   chosen_r, chosen_nxt;
  logic                   echo, done, tmo, step;
  logic [7:0]             dist_cm;
  logic [LW-1:0]          trig_lim, tmo_lim;
  logic                   trig_hit, tmo_hit;

  assign step = advance && item_vld;
  assign echo = chosen_r ? item.echo_right : item.echo_left;

  // limits, zero trigger length acts as one
  assign trig_lim = (trig_ticks_r == '0) ? LW'(1) : LW'(trig_ticks_r);
  assign tmo_lim  = LW'(tmo_ticks_r);

  // saturating increment for the trigger phase
  assign cnt_inc  = (cnt_r == CEIL) ? cnt_r : cnt_r + 1'b1;
  assign trig_hit = (LW'(cnt_inc) >= trig_lim) || (cnt_inc == CEIL);
  assign tmo_hit  = (LW'(cnt_r) >= tmo_lim) || (cnt_r == CEIL);

  // next state and result
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    chosen_nxt = chosen_r;
    done       = 1'b0;
    tmo        = 1'b0;
    dist_cm    = '0;
    if (item.command) begin
      if (phase_r == PH_IDLE) begin
        chosen_nxt = item.sensor_select;
        cnt_nxt    = '0;
        phase_nxt  = PH_TRIG;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_TRIG: begin
          cnt_nxt = cnt_inc;
          if (trig_hit) begin
            phase_nxt = PH_RISE;
            cnt_nxt   = '0;
          end
        end
        PH_RISE: begin
          if (echo) begin
            phase_nxt = PH_FALL;
            cnt_nxt   = '0;
          end else if (tmo_hit) begin
            done    = 1'b1;
            tmo     = 1'b1;
            dist_cm = TIMEOUT_DIST;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        PH_FALL: begin
          if (!echo) begin
            done    = 1'b1;
            dist_cm = uer_to_cm(32'(cnt_r));
          end else if (tmo_hit) begin
            done    = 1'b1;
            tmo     = 1'b1;
            dist_cm = TIMEOUT_DIST;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (done) begin
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
    end
  end

  // result fields seen after this item
  always_comb begin
    res.trigger_left  = (phase_nxt == PH_TRIG) && !chosen_nxt;
    res.trigger_right = (phase_nxt == PH_TRIG) && chosen_nxt;
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.done_res      = done;
    res.timed_out     = tmo;
    res.distance_cm   = dist_cm;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r <= TRIGGER_RESET;
      tmo_ticks_r  <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (uer_cfg_idx_t'(cfg_addr))
        CFG_TRIGGER_TICKS: trig_ticks_r <= cfg_wdata;
        CFG_TIMEOUT_TICKS: tmo_ticks_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // measurement state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= '0;
      chosen_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      chosen_r <= chosen_nxt;
    end
  end

endmodule

/* design/uer_out_reg.sv */
// ----------------------------------------------------------------------------
// uer_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module uer_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_vld,
  input  uer_pkg::uer_res_t res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output uer_pkg::uer_res_t out_res
);
  import uer_pkg::*;

  logic     vld_r;
  uer_res_t res_r;

  // the stage moves when the result slot is empty or being emptied
  assign advance = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= item_vld;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (advance && item_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule
